// ===== hdl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg: shared types for the modular exponentiation core
// Status word passed from the modular multiplier back to the sequencer.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // multiplier status towards the sequencer
    typedef struct packed {
        logic busy;   // a product is being formed
        logic done;   // one-cycle pulse, product valid
    } mexp_mul_stat_t;

endpackage

// ===== hdl/mexp_modmul.sv =====
// ----------------------------------------------------------------------------
// mexp_modmul: iterative modular multiplier
// Forms (opa * opb) mod modulus, one bit of opb per cycle, MSB first.
// Requires opa < modulus and modulus > 0. The accumulator stays below
// the modulus after every step.
// ----------------------------------------------------------------------------
module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int WIDTH = 31
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WIDTH-1:0]     opa,
    input  logic [WIDTH-1:0]     opb,
    input  logic [WIDTH-1:0]     modulus,
    output logic [WIDTH-1:0]     product,
    output mexp_mul_stat_t       stat
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(WIDTH - 1);

    logic [WIDTH-1:0] acc_reg,  acc_next;
    logic [WIDTH-1:0] opa_reg;
    logic [WIDTH-1:0] opb_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // one step: 2*acc + bit*opa, then take off 0, m or 2m
    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] diff1;
    logic [WIDTH+1:0] diff2;

    always_comb
    begin
        sum   = {1'b0, acc_reg, 1'b0}
              + (opb_reg[WIDTH-1] ? {2'b00, opa_reg} : {(WIDTH+2){1'b0}});
        diff1 = sum - {2'b00, modulus};
        diff2 = sum - {1'b0, modulus, 1'b0};
        if (!diff2[WIDTH+1])
        begin
            acc_next = diff2[WIDTH-1:0];
        end
        else if (!diff1[WIDTH+1])
        begin
            acc_next = diff1[WIDTH-1:0];
        end
        else
        begin
            acc_next = sum[WIDTH-1:0];
        end
    end

    // control: load on start, count down the multiplier bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_TOP;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            opa_reg <= opa;
            opb_reg <= opb;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            opb_reg <= {opb_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/modular_exponentiation_core.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_core: base ** exponent mod modulus
// Left-to-right square-and-multiply around one shared modular multiplier.
//
//   port group          dir   handshake            word
//   in  (base,exponent) in    in_valid/in_ready    one operand pair
//   out (result)        out   out_valid/out_ready  one result
//   APB (modulus)       in    psel/penable/pready  register 0, 4-byte step
//
// Each item runs one reduction of the base, OPERAND_BITS squarings and one
// multiply per set exponent bit, all in the shared multiplier. Exponent
// zero or modulus zero go straight to the finish state without the multiplier.
// in_ready is high only while the sequencer is idle; a finished word waits
// in the output register while the next pair is taken.
// Reset sets the modulus to 1 and clears all control state.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int OPERAND_BITS = 31
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // operand channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [OPERAND_BITS-1:0]       base,
    input  logic [OPERAND_BITS-1:0]       exponent,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [OPERAND_BITS-1:0]       result,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [((OPERAND_BITS > 32) ? 4 : 3)-1:0] paddr,
    input  logic [((OPERAND_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((OPERAND_BITS > 32) ? 64 : 32)-1:0] prdata,
    output logic                          pready
);

    localparam int N      = OPERAND_BITS;
    localparam int DATA_W = (N > 32) ? 64 : 32;
    localparam int ADDR_W = (N > 32) ? 4 : 3;
    localparam int CNT_W  = $clog2(N);
    localparam logic [CNT_W-1:0] BIT_TOP = CNT_W'(N - 1);
    localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_MULT   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       state_reg,   state_next;
    logic [N-1:0]     modulus_reg;
    logic [N-1:0]     exp_reg,     exp_next;
    logic [N-1:0]     base_reg,    base_next;
    logic [N-1:0]     r_reg,       r_next;
    logic [CNT_W-1:0] bit_reg,     bit_next;
    logic             start_reg,   start_next;
    logic [N-1:0]     opa_reg,     opa_next;
    logic [N-1:0]     opb_reg,     opb_next;
    logic             out_valid_reg;
    logic [N-1:0]     result_reg;
    logic             load_out;

    logic [N-1:0]     product;
    mexp_mul_stat_t   mul_stat;

    // register port
    logic cfg_write;
    assign cfg_write = psel & penable & pwrite & pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[ADDR_W-1] == 1'b0) ? DATA_W'(modulus_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= ONE;
        end
        else if (cfg_write && (paddr[ADDR_W-1] == 1'b0))
        begin
            modulus_reg <= pwdata[N-1:0];
        end
    end

    // shared multiplier
    mexp_modmul #(
        .WIDTH   (N)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .opa     (opa_reg),
        .opb     (opb_reg),
        .modulus (modulus_reg),
        .product (product),
        .stat    (mul_stat)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        exp_next   = exp_reg;
        base_next  = base_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        start_next = 1'b0;
        opa_next   = opa_reg;
        opb_next   = opb_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    exp_next = exponent;
                    if (exponent == '0)
                    begin
                        r_next     = ONE;
                        state_next = ST_FINISH;
                    end
                    else if (modulus_reg == '0)
                    begin
                        r_next     = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // base mod m as 1 * base mod m
                        opa_next   = ONE;
                        opb_next   = base;
                        start_next = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                if (mul_stat.done)
                begin
                    base_next  = product;
                    r_next     = (modulus_reg == ONE) ? '0 : ONE;
                    bit_next   = BIT_TOP;
                    opa_next   = (modulus_reg == ONE) ? '0 : ONE;
                    opb_next   = (modulus_reg == ONE) ? '0 : ONE;
                    start_next = 1'b1;
                    state_next = ST_SQUARE;
                end
            end

            ST_SQUARE:
            begin
                if (mul_stat.done)
                begin
                    r_next = product;
                    if (exp_reg[N-1])
                    begin
                        opa_next   = product;
                        opb_next   = base_reg;
                        start_next = 1'b1;
                        state_next = ST_MULT;
                    end
                    else if (bit_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 1'b1;
                        exp_next   = {exp_reg[N-2:0], 1'b0};
                        opa_next   = product;
                        opb_next   = product;
                        start_next = 1'b1;
                    end
                end
            end

            ST_MULT:
            begin
                if (mul_stat.done)
                begin
                    r_next = product;
                    if (bit_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 1'b1;
                        exp_next   = {exp_reg[N-2:0], 1'b0};
                        opa_next   = product;
                        opb_next   = product;
                        start_next = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end

            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            bit_reg   <= bit_next;
        end
    end

    // working operands
    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        base_reg <= base_next;
        r_reg    <= r_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg <= r_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== dv/mexp_result_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_result_checker: result predictor and scoreboard for the mexp core
// Watches the operand, result and APB channels. Keeps its own copy of the
// modulus, predicts base ** exponent mod modulus for every accepted operand
// word, and compares each accepted result word with the oldest prediction.
// Modulus read-backs are checked against the same copy.
// ----------------------------------------------------------------------------
module mexp_result_checker #(
    parameter int OPERAND_BITS = 31,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 32,
    parameter logic [ADDR_W-1:0] MODULUS_ADDR = '0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [OPERAND_BITS-1:0] base,
    input  logic [OPERAND_BITS-1:0] exponent,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [OPERAND_BITS-1:0] result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic                    pready,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    input  logic [DATA_W-1:0]       prdata,
    output int                      fail_count,
    output int                      pending
);

    typedef logic [OPERAND_BITS-1:0] operand_t;

    operand_t modulus_copy;
    operand_t expected_results[$];

    // right-to-left square-and-multiply on native 64-bit products
    function automatic operand_t power_mod(operand_t b, operand_t e, operand_t m);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] m64;
        operand_t    bits_left;
        if (e == '0)
            return operand_t'(1);
        if (m == '0)
            return '0;
        m64       = 64'(m);
        acc       = 64'd1 % m64;
        sq        = 64'(b) % m64;
        bits_left = e;
        while (bits_left != '0)
        begin
            if (bits_left[0])
                acc = (acc * sq) % m64;
            sq        = (sq * sq) % m64;
            bits_left = bits_left >> 1;
        end
        return operand_t'(acc);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        operand_t want;
        if (!rst_n)
        begin
            modulus_copy = operand_t'(1);
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            // result word: compare against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word %0d arrived with none expected", result);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result !== want)
                    begin
                        $error("result mismatch: expected %0d, actual %0d", want, result);
                        fail_count++;
                    end
                end
            end

            // operand word: predict with the modulus in force now
            if (in_valid && in_ready)
                expected_results.push_back(power_mod(base, exponent, modulus_copy));

            // APB access phase
            if (psel && penable && pready && paddr == MODULUS_ADDR)
            begin
                if (pwrite)
                    modulus_copy = pwdata[OPERAND_BITS-1:0];
                else if (prdata !== DATA_W'(modulus_copy))
                begin
                    $error("modulus mismatch: expected %0d, actual %0d",
                           modulus_copy, prdata);
                    fail_count++;
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for modular_exponentiation_core
// Directed operand words over the modulus extremes and special cases, then
// random words under changing moduli in three idling modes, one of them
// with a long result stall. Checking is left to mexp_result_checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int OPERAND_BITS = 31;
    localparam int ADDR_W = (OPERAND_BITS > 32) ? 4 : 3;
    localparam int DATA_W = (OPERAND_BITS > 32) ? 64 : 32;
    localparam logic [ADDR_W-1:0] MODULUS_ADDR = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] SPARE_ADDR   = ADDR_W'(4);   // no register here
    localparam logic [OPERAND_BITS-1:0] OP_MAX = '1;
    localparam int HOLD_CYCLES = 8000;
    localparam int WORDS_PER_BATCH = 22;

    typedef logic [OPERAND_BITS-1:0] operand_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    operand_t          base;
    operand_t          exponent;
    logic              out_valid;
    logic              out_ready = 1'b0;
    operand_t          result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int       fail_count;
    int       pending;
    int       tx_idle_pct = 29;
    int       rx_idle_pct = 61;
    int       hold_requests = 0;
    int       hold_granted = 0;
    int       hold_left = 0;
    operand_t cur_modulus;

    always #2 clk = ~clk;

    modular_exponentiation_core #(.OPERAND_BITS(OPERAND_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    mexp_result_checker #(
        .OPERAND_BITS (OPERAND_BITS),
        .ADDR_W       (ADDR_W),
        .DATA_W       (DATA_W),
        .MODULUS_ADDR (MODULUS_ADDR)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .base       (base),
        .exponent   (exponent),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_granted != hold_requests)
        begin
            out_ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_granted <= hold_granted + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // offer one operand word; returns at the edge that takes it, valid still high
    task automatic send_pair(operand_t b, operand_t e);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        base     <= b;
        exponent <= e;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic apb_access(logic wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_modulus(logic [DATA_W-1:0] data);
        apb_access(1'b1, MODULUS_ADDR, data);
        apb_access(1'b0, MODULUS_ADDR, '0);
        cur_modulus = data[OPERAND_BITS-1:0];
    endtask

    function automatic logic [DATA_W-1:0] pick_modulus();
        case ($urandom_range(5))
            0: return DATA_W'(1);
            1: return DATA_W'($urandom_range(255, 2));
            2: return DATA_W'(OP_MAX);
            3: return DATA_W'(operand_t'($urandom) | (OP_MAX ^ (OP_MAX >> 1)));   // top bit set
            default: return DATA_W'($urandom_range(OP_MAX, 1));
        endcase
    endfunction

    function automatic operand_t pick_base();
        case ($urandom_range(9))
            0: return '0;
            1: return OP_MAX;
            2: return cur_modulus;
            3: return cur_modulus - 1'b1;
            default: return operand_t'($urandom);
        endcase
    endfunction

    function automatic operand_t pick_exponent();
        case ($urandom_range(9))
            0: return '0;
            1: return operand_t'($urandom_range(15, 1));
            2: return OP_MAX;
            default: return operand_t'($urandom);
        endcase
    endfunction

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        base     <= '0;
        exponent <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cur_modulus = operand_t'(1);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus of one
        apb_access(1'b0, MODULUS_ADDR, '0);
        send_pair(operand_t'(5), '0);
        send_pair(OP_MAX, OP_MAX);
        send_pair('0, '0);

        // largest modulus: operand extremes, base equal to modulus, bit patterns
        drain();
        set_modulus(DATA_W'(OP_MAX));
        send_pair('0, '0);
        send_pair('0, operand_t'(1));
        send_pair(operand_t'(1), OP_MAX);
        send_pair(OP_MAX, OP_MAX);
        send_pair(OP_MAX - 1'b1, OP_MAX - 1'b1);
        send_pair(operand_t'(2), operand_t'(31'h4000_0000));
        send_pair(operand_t'(31'h5555_5555), operand_t'(31'h2AAA_AAAA));
        send_pair(operand_t'(31'h2AAA_AAAA), operand_t'(31'h5555_5555));
        send_pair(operand_t'(12345), operand_t'(1));

        // modulus zero, written with the bit above the field set
        drain();
        set_modulus(DATA_W'(32'h8000_0000));
        send_pair(operand_t'(7), '0);
        send_pair(operand_t'(7), operand_t'(9));

        // write to a missing register must leave the modulus alone
        drain();
        apb_access(1'b1, SPARE_ADDR, DATA_W'(32'h0123_4567));
        apb_access(1'b0, MODULUS_ADDR, '0);
        set_modulus(DATA_W'(2));
        send_pair(operand_t'(3), operand_t'(7));
        send_pair(OP_MAX, operand_t'(2));
        send_pair(operand_t'(4), operand_t'(3));

        // random words across the three idling modes
        for (int mode = 0; mode < 3; mode++)
        begin
            for (int batch = 0; batch < 4; batch++)
            begin
                drain();
                case (mode)
                    0: begin tx_idle_pct = 29; rx_idle_pct = 61; end
                    1: begin tx_idle_pct = 61; rx_idle_pct = 29; end
                    default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
                endcase
                set_modulus(pick_modulus());
                if (mode == 2 && batch == 1)
                    hold_requests++;
                for (int k = 0; k < WORDS_PER_BATCH; k++)
                    send_pair(pick_base(), pick_exponent());
            end
        end

        drain();
        repeat (64) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial
    begin
        #13_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mexp_pkg.sv
hdl/mexp_modmul.sv
hdl/modular_exponentiation_core.sv
dv/mexp_result_checker.sv
dv/tb.sv
